>>> hw/rtl/countdown_timer_set_core_macros.svh
// ----------------------------------------------------------------------------
// Countdown timer set assertion macros
// Shared concurrent assertion forms for the timer set checker.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_SET_CORE_MACROS_SVH
`define COUNTDOWN_TIMER_SET_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer set package
// Sizes, command codes, timer modes and shared types of the timer set.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Sizes of the timer table.
  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Fixed port field widths.
  localparam int CMD_W = 2;
  localparam int TID_W = 4;
  localparam int SV_W  = 16;
  localparam int EID_W = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // Mode of one timer.
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_EXPIRED = 2'd2
  } timer_mode_t;

  // Contents of one cell.
  typedef struct packed {
    timer_mode_t            mode;
    logic [COUNT_WIDTH-1:0] count;
  } timer_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;
    logic load;
    logic stop;
  } cell_ctl_t;

endpackage

>>> hw/rtl/cts_cell.sv
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer's mode and count and takes its neighbor's contents on a shift.
// ----------------------------------------------------------------------------
module cts_cell
  import cts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctl_t              ctl,
  input  logic [COUNT_WIDTH-1:0] load_value,
  input  timer_t                 nb,
  output timer_t                 q
);

  timer_mode_t            mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  // A shift has priority; start and stop only occur while the ring is at rest.
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    if (ctl.shift) begin
      mode_nxt  = nb.mode;
      count_nxt = nb.count;
    end else if (ctl.load) begin
      mode_nxt  = MODE_RUNNING;
      count_nxt = load_value;
    end else if (ctl.stop) begin
      mode_nxt  = MODE_STOPPED;
    end
  end

  // The mode is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STOPPED;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // The count is only read for running timers, so it needs no reset.
  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign q.mode  = mode_r;
  assign q.count = count_r;

endmodule

>>> hw/rtl/cts_ctrl.sv
// ----------------------------------------------------------------------------
// Timer set controller
// Runs the tick scan around the cell ring and holds the output word register.
// ----------------------------------------------------------------------------
module cts_ctrl
  import cts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [CMD_W-1:0]      in_cmd,
  output logic                  in_stall,
  input  logic [NUM_TIMERS-1:0] exp_vec,
  input  timer_t                head,
  output timer_t                head_nxt,
  output logic                  shift,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [EID_W-1:0]      out_expired_id,
  output logic                  out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } ctrl_state_t;

  ctrl_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic [NUM_TIMERS-1:0] rem_r, rem_nxt;
  logic [NUM_TIMERS-1:0] rem_clr;
  logic                  out_valid_r, out_valid_nxt;
  logic [EID_W-1:0]      out_id_r, out_id_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  idle;
  logic                  tick_acc;
  logic                  head_exp;
  logic                  slot_free;
  logic                  last_step;

  assign idle      = (state_r == ST_IDLE);
  assign in_stall  = !idle;
  assign tick_acc  = in_valid && idle && (in_cmd == CMD_TICK);
  assign last_step = (step_r == IDX_W'(NUM_TIMERS - 1));

  // The head cell holds timer step_r; it expires when a running count is one.
  assign head_exp  = (head.mode == MODE_RUNNING) && (head.count == COUNT_WIDTH'(1));
  assign slot_free = !out_valid_r || !out_stall;
  assign shift     = (state_r == ST_SCAN) && (slot_free || !head_exp);

  // Expiries still ahead in this tick decide the last flag.
  assign rem_clr = rem_r & ~(NUM_TIMERS'(1) << step_r);

  // Decrement a running head timer on its way to the tail of the ring.
  always_comb begin
    head_nxt = head;
    if (head.mode == MODE_RUNNING) begin
      head_nxt.count = head.count - COUNT_WIDTH'(1);
      if (head_exp) begin
        head_nxt.mode = MODE_EXPIRED;
      end
    end
  end

  // Scan sequencer: one timer per cycle, held while a report cannot leave.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_SCAN;
          step_nxt  = '0;
          rem_nxt   = exp_vec;
        end
      end
      ST_SCAN: begin
        if (shift) begin
          step_nxt = step_r + 1'b1;
          rem_nxt  = rem_clr;
          if (last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output word register.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    if (shift && head_exp) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = EID_W'(step_r);
      out_last_nxt  = (rem_clr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

endmodule

>>> hw/rtl/countdown_timer_set_core.sv
// ----------------------------------------------------------------------------
// Countdown timer set core
// A table of countdown timers kept in a ring of cells that rotates once per tick.
//
//   Channel  Direction  Word
//   in_      input      in_cmd, in_timer_id, in_start_value
//   out_     output     out_expired_id, out_last
//
// A start or stop is applied to its cell in place.
// A tick is accepted while idle, then the ring makes one rotation in which
// the head cell updates one timer per cycle unless a stalled output holds it,
// so timers are reported in ascending order. A stalled output holds the
// rotation only on a cycle that has a report.
// in_stall is high during the tick rotation. Reset clears all modes to stopped.
// ----------------------------------------------------------------------------
module countdown_timer_set_core
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [TID_W-1:0] in_timer_id,
  input  logic [SV_W-1:0]  in_start_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [EID_W-1:0] out_expired_id,
  output logic             out_last
);

  timer_t                 cell_q [NUM_TIMERS];
  timer_t                 cell_d [NUM_TIMERS];
  timer_t                 head_nxt;
  logic [NUM_TIMERS-1:0]  exp_vec;
  logic                   shift;
  logic                   accept;
  logic                   start_ok;
  logic                   stop_ok;
  logic [COUNT_WIDTH-1:0] load_value;

  assign accept     = in_valid && !in_stall;
  assign load_value = COUNT_WIDTH'(in_start_value);
  assign start_ok   = accept && (in_cmd == CMD_START) && (load_value != '0);
  assign stop_ok    = accept && (in_cmd == CMD_STOP);

  // Ring of timer cells: each takes its upper neighbor, the tail takes the head.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    cell_ctl_t ctl;

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign cell_d[i] = head_nxt;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end

    assign ctl.shift  = shift;
    assign ctl.load   = start_ok && (32'(in_timer_id) == 32'(i));
    assign ctl.stop   = stop_ok && (32'(in_timer_id) == 32'(i));
    assign exp_vec[i] = (cell_q[i].mode == MODE_RUNNING) &&
                        (cell_q[i].count == COUNT_WIDTH'(1));

    cts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load_value (load_value),
      .nb         (cell_d[i]),
      .q          (cell_q[i])
    );
  end

  // Tick scan and output register.
  cts_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_cmd         (in_cmd),
    .in_stall       (in_stall),
    .exp_vec        (exp_vec),
    .head           (cell_q[0]),
    .head_nxt       (head_nxt),
    .shift          (shift),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

endmodule

>>> hw/rtl/cts_checker.sv
// ----------------------------------------------------------------------------
// Timer set port checker
// Watches the top level's ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
`include "countdown_timer_set_core_macros.svh"

module cts_checker
  import cts_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [CMD_W-1:0] in_cmd,
  input logic             out_valid,
  input logic             out_stall,
  input logic [EID_W-1:0] out_expired_id,
  input logic             out_last
);

  logic           in_acc;
  logic           is_tick;
  logic           out_wait;
  logic [EID_W:0] out_word;

  assign in_acc   = in_valid && !in_stall;
  assign is_tick  = (in_cmd == CMD_TICK);
  assign out_wait = out_valid && out_stall;
  assign out_word = {out_expired_id, out_last};

  // A stalled result word stays put.
  `CTS_ASSERT_NXT(a_out_hold, out_wait, out_valid && $stable(out_word), "stalled word changed")

  // An accepted tick closes the input while the ring rotates.
  `CTS_ASSERT_NXT(a_tick_busy, in_acc && is_tick, in_stall, "input open right after a tick")

  // A new report only comes out of a tick scan.
  `CTS_ASSERT_IMP(a_report_in_scan, $rose(out_valid), $past(in_stall), "report outside a scan")

  // Start and stop words never cause a report.
  `CTS_ASSERT_NXT(a_no_cmd_report, in_acc && !is_tick, !$rose(out_valid), "report after a command")

endmodule

bind countdown_timer_set_core cts_checker u_cts_checker (.*);
